// ===== sv/bsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the Bloom similarity cache.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int CacheEntriesDefault = 16;
    localparam int BloomBitsDefault    = 64;
    localparam int SlotW               = 4;
    localparam int FillW               = 5;
    localparam int ThrW                = 7;
    localparam int CfgIdxW             = 1;
    localparam logic [ThrW-1:0] ThrReset = 7'd50;

    localparam logic [CfgIdxW-1:0] CFG_THR_OPEN = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_THR_FULL = 1'b1;

    localparam logic [2:0] OUT_REJECT    = 3'd0;
    localparam logic [2:0] OUT_APPEND    = 3'd1;
    localparam logic [2:0] OUT_APPEND_OW = 3'd2;
    localparam logic [2:0] OUT_EVICT     = 3'd3;
    localparam logic [2:0] OUT_REPLACE   = 3'd4;
    localparam logic [2:0] OUT_REFRESH   = 3'd5;

    // One stored entry.
    typedef struct packed {
        logic [63:0] bloom;
        logic [63:0] owner_hi;
        logic [63:0] owner_lo;
        logic [63:0] prov_hi;
        logic [63:0] prov_lo;
        logic [31:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WRITE,
        ST_READ,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// ===== sv/bsc_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_table
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsc_table #(
    parameter int Entries = 16,
    parameter int AddrW   = 4
) (
    input  wire                 clk,
    input  wire                 wr_en,
    input  wire [AddrW-1:0]     wr_addr,
    input  wire bsc_pkg::entry_t wr_data,
    input  wire [AddrW-1:0]     rd_addr,
    output bsc_pkg::entry_t     rd_data
);
    import bsc_pkg::*;

    entry_t mem_reg [Entries];

    // Synchronous write and read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/bloom_similarity_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_similarity_cache
// Bloom-name cache with similarity-based admission and nearest-entry query.
// ----------------------------------------------------------------------------
// Usage: an item beat on the input channel (kind, bloom, addresses, stamp)
// is either an add or a query. Exactly one result beat follows per item.
// The table lives in a single-port-read memory; each item scans the filled
// entries one per cycle, so the time an item takes grows with the fill
// count; a refresh also reads the stored entry back before its write.
// One item is in flight at a time; the next item is accepted the cycle
// after the previous result beat has been taken.
// The memory is not cleared: only entries below the fill count are used,
// and a query on an empty table reports zero fields. Reset empties the
// table and sets both thresholds to 50.
// When the receiver stalls, the result is held in the output registers
// until taken. Configuration writes take effect at once; the user must make
// them only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module bloom_similarity_cache #(
    parameter int CACHE_ENTRIES = bsc_pkg::CacheEntriesDefault,
    parameter int BLOOM_BITS    = bsc_pkg::BloomBitsDefault
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [bsc_pkg::CfgIdxW-1:0] cfg_index,
    input  wire [bsc_pkg::ThrW-1:0]    cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         kind,
    input  wire [63:0]  bloom,
    input  wire [63:0]  owner_addr_hi,
    input  wire [63:0]  owner_addr_lo,
    input  wire [63:0]  provider_addr_hi,
    input  wire [63:0]  provider_addr_lo,
    input  wire [31:0]  stamp,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [2:0]  outcome,
    output logic [3:0]  slot,
    output logic        found,
    output logic [63:0] slot_bloom,
    output logic [63:0] slot_owner_hi,
    output logic [63:0] slot_owner_lo,
    output logic [63:0] slot_provider_hi,
    output logic [63:0] slot_provider_lo,
    output logic [31:0] slot_stamp,
    output logic [4:0]  fill_count
);
    import bsc_pkg::*;

    localparam int AddrW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CntW   = $clog2(CACHE_ENTRIES + 1);
    localparam int DistW  = $clog2(BLOOM_BITS + 1);
    localparam int SumW   = $clog2(CACHE_ENTRIES * BLOOM_BITS + 1);
    localparam int ProdW  = SumW + 7;
    localparam logic [63:0] BloomMask = {64{1'b1}} >> (64 - BLOOM_BITS);

    // Configuration registers.
    logic [ThrW-1:0] thr_open_reg, thr_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_open_reg <= ThrReset;
            thr_full_reg <= ThrReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THR_OPEN: thr_open_reg <= cfg_data;
                CFG_THR_FULL: thr_full_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control and scan registers.
    state_t             state_reg, state_next;
    logic [CntW-1:0]    count_reg, count_next;
    logic [CntW-1:0]    idx_reg, idx_next;     // address issued
    logic [CntW-1:0]    chk_reg, chk_next;     // entry whose data arrives
    logic               chk_vld_reg, chk_vld_next;
    logic               kind_reg;
    entry_t             item_reg;
    logic               hit_reg, hit_next;
    logic [AddrW-1:0]   match_reg, match_next;
    logic [AddrW-1:0]   oldest_reg, oldest_next;
    logic [31:0]        low_reg, low_next;
    logic [SumW-1:0]    sum_reg, sum_next;
    logic [DistW-1:0]   best_d_reg, best_d_next;
    logic [AddrW-1:0]   best_reg, best_next;
    logic               qfound_reg, qfound_next;
    logic               mowner_reg, mowner_next;
    logic [ProdW-1:0]   sim_reg, thr_d_reg;
    logic [2:0]         oc_reg, oc_next;
    logic [AddrW-1:0]   tgt_reg, tgt_next;
    logic               out_valid_reg;
    logic [2:0]         outcome_reg;
    logic [AddrW-1:0]   slot_reg;
    logic               found_reg;
    entry_t             slot_data_reg;

    // Memory.
    logic               wr_en;
    logic [AddrW-1:0]   wr_addr;
    entry_t             wr_data;
    logic [AddrW-1:0]   rd_addr;
    entry_t             rd_data;

    bsc_table #(
        .Entries (CACHE_ENTRIES),
        .AddrW   (AddrW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Hamming distance of the returning entry.
    logic [DistW-1:0] ham_d;
    logic [63:0]      diff;
    always_comb
    begin
        diff = (rd_data.bloom ^ item_reg.bloom) & BloomMask;
        ham_d = '0;
        for (int b = 0; b < 64; b++)
        begin
            ham_d = ham_d + DistW'(diff[b]);
        end
    end

    logic full;
    assign full = (count_reg >= CntW'(CACHE_ENTRIES));

    logic prov_diff;
    assign prov_diff = (rd_data.prov_hi != item_reg.prov_hi) ||
                       (rd_data.prov_lo != item_reg.prov_lo);

    // Next state and datapath control.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        chk_next     = chk_reg;
        chk_vld_next = 1'b0;
        hit_next     = hit_reg;
        match_next   = match_reg;
        oldest_next  = oldest_reg;
        low_next     = low_reg;
        sum_next     = sum_reg;
        best_d_next  = best_d_reg;
        best_next    = best_reg;
        qfound_next  = qfound_reg;
        mowner_next  = mowner_reg;
        oc_next      = oc_reg;
        tgt_next     = tgt_reg;
        in_ready     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = tgt_reg;
        wr_data      = item_reg;
        rd_addr      = idx_reg[AddrW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !out_valid_reg;
                if (in_valid && in_ready)
                begin
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    match_next  = '0;
                    oldest_next = '0;
                    sum_next    = '0;
                    best_d_next = DistW'(BLOOM_BITS);
                    best_next   = '0;
                    qfound_next = 1'b0;
                    mowner_next = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Issue reads for entries below the count, consume one behind.
                if (idx_reg < count_reg)
                begin
                    chk_vld_next = 1'b1;
                    chk_next     = idx_reg;
                    idx_next     = idx_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (chk_reg == '0)
                    begin
                        low_next = rd_data.stamp;
                    end
                    else if (rd_data.stamp < low_reg)
                    begin
                        low_next    = rd_data.stamp;
                        oldest_next = chk_reg[AddrW-1:0];
                    end
                    sum_next = sum_reg + SumW'(ham_d);
                    if (ham_d == '0 && !hit_reg)
                    begin
                        hit_next    = 1'b1;
                        match_next  = chk_reg[AddrW-1:0];
                        mowner_next = (rd_data.owner_hi == item_reg.owner_hi) &&
                                      (rd_data.owner_lo == item_reg.owner_lo);
                    end
                    if (prov_diff && ham_d < best_d_reg)
                    begin
                        best_d_next = ham_d;
                        best_next   = chk_reg[AddrW-1:0];
                        qfound_next = 1'b1;
                    end
                end
                if (!(idx_reg < count_reg) && !chk_vld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                tgt_next = '0;
                oc_next  = OUT_REJECT;
                if (kind_reg)
                begin
                    tgt_next   = best_reg;
                    state_next = ST_READ;
                end
                else
                begin
                    if (!hit_reg)
                    begin
                        if (!full && (count_reg == '0 || sim_reg > thr_d_reg))
                        begin
                            oc_next  = OUT_APPEND;
                            tgt_next = count_reg[AddrW-1:0];
                        end
                        else if (full && sim_reg > thr_d_reg)
                        begin
                            oc_next  = OUT_EVICT;
                            tgt_next = oldest_reg;
                        end
                    end
                    else if (mowner_reg)
                    begin
                        oc_next  = OUT_REFRESH;
                        tgt_next = match_reg;
                    end
                    else if (!full)
                    begin
                        oc_next  = OUT_APPEND_OW;
                        tgt_next = count_reg[AddrW-1:0];
                    end
                    else
                    begin
                        oc_next  = OUT_REPLACE;
                        tgt_next = match_reg;
                    end
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // Refresh needs the stored entry: read it first.
                if (oc_reg == OUT_REFRESH)
                begin
                    rd_addr    = tgt_reg;
                    state_next = ST_READ;
                end
                else
                begin
                    wr_en = (oc_reg != OUT_REJECT);
                    if (oc_reg == OUT_APPEND || oc_reg == OUT_APPEND_OW)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_READ:
            begin
                rd_addr    = tgt_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (oc_reg == OUT_REFRESH && !kind_reg)
                begin
                    wr_en         = 1'b1;
                    wr_data       = rd_data;
                    wr_data.stamp = item_reg.stamp;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Product terms for the admission test, registered off the scan.
    logic [ProdW-1:0] d_full, sim_next, thr_d_next;
    always_comb
    begin
        d_full     = ProdW'(count_reg) * ProdW'(BLOOM_BITS);
        sim_next   = ProdW'(7'd100) * (d_full - ProdW'(sum_reg));
        thr_d_next = ProdW'(full ? thr_full_reg : thr_open_reg) * d_full;
    end

    always_ff @(posedge clk)
    begin
        sim_reg   <= sim_next;
        thr_d_reg <= thr_d_next;
        if (state_reg == ST_IDLE && in_valid && in_ready)
        begin
            kind_reg       <= kind;
            item_reg.bloom    <= bloom & BloomMask;
            item_reg.owner_hi <= owner_addr_hi;
            item_reg.owner_lo <= owner_addr_lo;
            item_reg.prov_hi  <= provider_addr_hi;
            item_reg.prov_lo  <= provider_addr_lo;
            item_reg.stamp    <= stamp;
        end
        chk_reg    <= chk_next;
        match_reg  <= match_next;
        oldest_reg <= oldest_next;
        low_reg    <= low_next;
        sum_reg    <= sum_next;
        best_d_reg <= best_d_next;
        best_reg   <= best_next;
        qfound_reg <= qfound_next;
        mowner_reg <= mowner_next;
        oc_reg     <= oc_next;
        tgt_reg    <= tgt_next;
        hit_reg    <= hit_next;
        idx_reg    <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            found_reg <= kind_reg & qfound_reg;
            if (kind_reg)
            begin
                outcome_reg   <= OUT_REJECT;
                slot_reg      <= tgt_reg;
                slot_data_reg <= (count_reg == '0) ? '0 : rd_data;
            end
            else
            begin
                outcome_reg <= oc_reg;
                slot_reg    <= tgt_reg;
                if (oc_reg == OUT_REJECT)
                begin
                    slot_data_reg <= '0;
                end
                else if (oc_reg == OUT_REFRESH)
                begin
                    // The write-back word already carries the new stamp.
                    slot_data_reg <= wr_data;
                end
                else
                begin
                    slot_data_reg <= item_reg;
                end
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign outcome          = outcome_reg;
    assign slot             = 4'(slot_reg);
    assign found            = found_reg;
    assign slot_bloom       = slot_data_reg.bloom;
    assign slot_owner_hi    = slot_data_reg.owner_hi;
    assign slot_owner_lo    = slot_data_reg.owner_lo;
    assign slot_provider_hi = slot_data_reg.prov_hi;
    assign slot_provider_lo = slot_data_reg.prov_lo;
    assign slot_stamp       = slot_data_reg.stamp;
    assign fill_count       = 5'(count_reg);

endmodule
`default_nettype wire

// ===== tb/bloom_similarity_cache_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_similarity_cache_checker
// Watches the item, result and register ports of the Bloom similarity cache.
// It keeps its own copy of the table, predicts the result beat of every
// accepted item and compares each result beat, field by field, in order.
// ----------------------------------------------------------------------------
module bloom_similarity_cache_checker
    import bsc_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int BITS    = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [CfgIdxW-1:0] cfg_index,
    input  wire [ThrW-1:0]    cfg_data,
    input  wire         in_valid,
    input  wire         in_ready,
    input  wire         kind,
    input  wire [63:0]  bloom,
    input  wire [63:0]  owner_addr_hi,
    input  wire [63:0]  owner_addr_lo,
    input  wire [63:0]  provider_addr_hi,
    input  wire [63:0]  provider_addr_lo,
    input  wire [31:0]  stamp,
    input  wire         out_valid,
    input  wire         out_ready,
    input  wire [2:0]   outcome,
    input  wire [3:0]   slot,
    input  wire         found,
    input  wire [63:0]  slot_bloom,
    input  wire [63:0]  slot_owner_hi,
    input  wire [63:0]  slot_owner_lo,
    input  wire [63:0]  slot_provider_hi,
    input  wire [63:0]  slot_provider_lo,
    input  wire [31:0]  slot_stamp,
    input  wire [4:0]   fill_count,
    output int          errors,
    output int          pending,
    output int          results_seen
);

    localparam logic [63:0] BitsMask = {64{1'b1}} >> (64 - BITS);

    typedef struct packed {
        logic [2:0]  outcome;
        logic [3:0]  slot;
        logic        found;
        entry_t      fields;
        logic [4:0]  fill;
    } cache_result_t;

    entry_t          table_copy [ENTRIES];
    int unsigned     fill_level;
    logic [ThrW-1:0] thr_open;
    logic [ThrW-1:0] thr_full;
    cache_result_t   expected_beats [$];

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    // Works out the result beat of one item and updates the table copy.
    function automatic cache_result_t predict_cache_step(input entry_t it, input logic is_query);
        cache_result_t  res;
        int unsigned    n;
        int unsigned    best;
        int unsigned    near_d;
        int unsigned    h;
        int unsigned    match;
        int unsigned    oldest;
        logic [31:0]    low;
        longint unsigned sum;
        longint unsigned d;
        longint unsigned sim;
        longint unsigned thr;
        logic           full;
        logic           hit;
        int unsigned    s;
        res = '0;
        n = fill_level;
        s = 0;
        if (is_query)
        begin
            best = 0;
            near_d = BITS;
            hit = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (table_copy[i].prov_hi != it.prov_hi || table_copy[i].prov_lo != it.prov_lo)
                begin
                    h = $countones(table_copy[i].bloom ^ it.bloom);
                    if (h < near_d)
                    begin
                        near_d = h;
                        best = i;
                        hit = 1'b1;
                    end
                end
            end
            res.slot = best[3:0];
            res.found = hit;
            res.fields = table_copy[best];
        end
        else
        begin
            match = n;
            oldest = 0;
            sum = 0;
            low = table_copy[0].stamp;
            full = (n >= ENTRIES);
            for (int i = 0; i < n; i++)
            begin
                h = $countones(table_copy[i].bloom ^ it.bloom);
                if (h == 0 && match == n)
                    match = i;
                sum += h;
                if (table_copy[i].stamp < low)
                begin
                    low = table_copy[i].stamp;
                    oldest = i;
                end
            end
            d = longint'(n) * BITS;
            sim = 100 * (d - sum);
            thr = full ? thr_full : thr_open;
            res.outcome = OUT_REJECT;
            if (match == n)
            begin
                if (!full && (n == 0 || sim > thr * d))
                begin
                    table_copy[n] = it;
                    s = n;
                    fill_level = n + 1;
                    res.outcome = OUT_APPEND;
                end
                else if (full && sim > thr * d)
                begin
                    table_copy[oldest] = it;
                    s = oldest;
                    res.outcome = OUT_EVICT;
                end
            end
            else if (table_copy[match].owner_hi == it.owner_hi &&
                     table_copy[match].owner_lo == it.owner_lo)
            begin
                table_copy[match].stamp = it.stamp;
                s = match;
                res.outcome = OUT_REFRESH;
            end
            else if (!full)
            begin
                table_copy[n] = it;
                s = n;
                fill_level = n + 1;
                res.outcome = OUT_APPEND_OW;
            end
            else
            begin
                table_copy[match] = it;
                s = match;
                res.outcome = OUT_REPLACE;
            end
            // A rejected add reports slot zero with all fields clear.
            if (res.outcome != OUT_REJECT)
            begin
                res.slot = s[3:0];
                res.fields = table_copy[s];
            end
        end
        res.fill = fill_level[4:0];
        return res;
    endfunction

    // Register writes, result comparison and prediction, in beat order.
    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t want;
        entry_t        item;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                table_copy[i] = '0;
            fill_level = 0;
            thr_open = ThrReset;
            thr_full = ThrReset;
            expected_beats.delete();
            errors = 0;
            pending = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_THR_OPEN)
                    thr_open = cfg_data;
                else if (cfg_index == CFG_THR_FULL)
                    thr_full = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_beats.size() == 0)
                begin
                    $display("%0t ns: result beat with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (outcome != want.outcome)
                        report_mismatch("outcome", outcome, want.outcome);
                    if (slot != want.slot)
                        report_mismatch("slot", slot, want.slot);
                    if (found != want.found)
                        report_mismatch("found", found, want.found);
                    if (slot_bloom != want.fields.bloom)
                        report_mismatch("slot_bloom", slot_bloom, want.fields.bloom);
                    if (slot_owner_hi != want.fields.owner_hi)
                        report_mismatch("slot_owner_hi", slot_owner_hi, want.fields.owner_hi);
                    if (slot_owner_lo != want.fields.owner_lo)
                        report_mismatch("slot_owner_lo", slot_owner_lo, want.fields.owner_lo);
                    if (slot_provider_hi != want.fields.prov_hi)
                        report_mismatch("slot_provider_hi", slot_provider_hi,
                                        want.fields.prov_hi);
                    if (slot_provider_lo != want.fields.prov_lo)
                        report_mismatch("slot_provider_lo", slot_provider_lo,
                                        want.fields.prov_lo);
                    if (slot_stamp != want.fields.stamp)
                        report_mismatch("slot_stamp", slot_stamp, want.fields.stamp);
                    if (fill_count != want.fill)
                        report_mismatch("fill_count", fill_count, want.fill);
                end
            end
            if (in_valid && in_ready)
            begin
                item.bloom = bloom & BitsMask;
                item.owner_hi = owner_addr_hi;
                item.owner_lo = owner_addr_lo;
                item.prov_hi = provider_addr_hi;
                item.prov_lo = provider_addr_lo;
                item.stamp = stamp;
                expected_beats.push_back(predict_cache_step(item, kind));
            end
            pending = expected_beats.size();
        end
    end

endmodule

// ===== tb/bloom_similarity_cache_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_similarity_cache_test
// Drives add and query beats into the Bloom similarity cache under several
// threshold settings, with random idling on both channels, a long output
// stall and a full drain pause; the checker beside the block does the rest.
// ----------------------------------------------------------------------------
module bloom_similarity_cache_test;
    import bsc_pkg::*;

    localparam int RandomItems = 1430;
    localparam int CycleLimit  = 600000;
    localparam int PhaseLen    = 160;

    typedef struct {
        logic        kind;
        logic [63:0] bloom;
        logic [63:0] own_hi;
        logic [63:0] own_lo;
        logic [63:0] prov_hi;
        logic [63:0] prov_lo;
        logic [31:0] stamp;
    } cache_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = CFG_THR_OPEN;
    logic [ThrW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic [63:0] bloom = '0;
    logic [63:0] owner_addr_hi = '0;
    logic [63:0] owner_addr_lo = '0;
    logic [63:0] provider_addr_hi = '0;
    logic [63:0] provider_addr_lo = '0;
    logic [31:0] stamp = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] outcome;
    logic [3:0] slot;
    logic found;
    logic [63:0] slot_bloom, slot_owner_hi, slot_owner_lo;
    logic [63:0] slot_provider_hi, slot_provider_lo;
    logic [31:0] slot_stamp;
    logic [4:0] fill_count;

    int errors;
    int pending;
    int results_seen;
    int cycles = 0;
    int items_sent = 0;
    int settings_used = 0;
    bit quiet = 1'b0;
    bit hold_long = 1'b0;

    logic [63:0] bloom_pool [8];
    logic [63:0] owner_pool [3][2];
    logic [63:0] prov_pool [3][2];

    bloom_similarity_cache i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .bloom(bloom),
        .owner_addr_hi(owner_addr_hi), .owner_addr_lo(owner_addr_lo),
        .provider_addr_hi(provider_addr_hi), .provider_addr_lo(provider_addr_lo),
        .stamp(stamp),
        .out_valid(out_valid), .out_ready(out_ready),
        .outcome(outcome), .slot(slot), .found(found),
        .slot_bloom(slot_bloom), .slot_owner_hi(slot_owner_hi),
        .slot_owner_lo(slot_owner_lo), .slot_provider_hi(slot_provider_hi),
        .slot_provider_lo(slot_provider_lo), .slot_stamp(slot_stamp),
        .fill_count(fill_count)
    );

    bloom_similarity_cache_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .bloom(bloom),
        .owner_addr_hi(owner_addr_hi), .owner_addr_lo(owner_addr_lo),
        .provider_addr_hi(provider_addr_hi), .provider_addr_lo(provider_addr_lo),
        .stamp(stamp),
        .out_valid(out_valid), .out_ready(out_ready),
        .outcome(outcome), .slot(slot), .found(found),
        .slot_bloom(slot_bloom), .slot_owner_hi(slot_owner_hi),
        .slot_owner_lo(slot_owner_lo), .slot_provider_hi(slot_provider_hi),
        .slot_provider_lo(slot_provider_lo), .slot_stamp(slot_stamp),
        .fill_count(fill_count),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_long = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet)
                    repeat ($urandom_range(0, 20)) @(posedge clk);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one item beat and waits until it is taken.
    task automatic send_item(input cache_item_t it);
        in_valid <= 1'b1;
        kind <= it.kind;
        bloom <= it.bloom;
        owner_addr_hi <= it.own_hi;
        owner_addr_lo <= it.own_lo;
        provider_addr_hi <= it.prov_hi;
        provider_addr_lo <= it.prov_lo;
        stamp <= it.stamp;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Writes both thresholds once the block has gone idle.
    task automatic set_thresholds(input logic [ThrW-1:0] open_thr,
                                  input logic [ThrW-1:0] full_thr);
        wait_drained();
        repeat (30) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_THR_OPEN;
        cfg_data <= open_thr;
        @(posedge clk);
        cfg_index <= CFG_THR_FULL;
        cfg_data <= full_thr;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Mostly names close to a small set of base names, with shared owners
    // and providers, so that hits, refreshes and evictions all come up.
    function automatic cache_item_t random_item();
        cache_item_t it;
        int p;
        it.kind = ($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 99) < 80)
        begin
            it.bloom = bloom_pool[$urandom_range(0, 7)];
            repeat ($urandom_range(0, 6))
                it.bloom[$urandom_range(0, 63)] ^= 1'b1;
        end
        else
            it.bloom = rand64();
        p = $urandom_range(0, 2);
        it.own_hi = owner_pool[p][0];
        it.own_lo = owner_pool[p][1];
        if ($urandom_range(0, 99) < 15)
        begin
            it.own_hi = rand64();
            it.own_lo = rand64();
        end
        p = $urandom_range(0, 2);
        it.prov_hi = prov_pool[p][0];
        it.prov_lo = prov_pool[p][1];
        if ($urandom_range(0, 99) < 15)
        begin
            it.prov_hi = rand64();
            it.prov_lo = rand64();
        end
        it.stamp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom;
        return it;
    endfunction

    function automatic cache_item_t make_item(input logic k, input logic [63:0] b,
                                              input logic [63:0] oh, input logic [63:0] ol,
                                              input logic [63:0] ph, input logic [63:0] pl,
                                              input logic [31:0] st);
        cache_item_t it;
        it.kind = k;
        it.bloom = b;
        it.own_hi = oh;
        it.own_lo = ol;
        it.prov_hi = ph;
        it.prov_lo = pl;
        it.stamp = st;
        return it;
    endfunction

    // Stimulus and verdict.
    initial
    begin
        cache_item_t it;
        logic [63:0] ones;
        int sel;
        ones = '1;
        for (int i = 0; i < 8; i++)
            bloom_pool[i] = rand64();
        for (int i = 0; i < 3; i++)
        begin
            owner_pool[i][0] = rand64();
            owner_pool[i][1] = rand64();
            prov_pool[i][0] = rand64();
            prov_pool[i][1] = rand64();
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, extremes of the fields, every outcome but replace.
        send_item(make_item(1'b1, ones, '0, '0, '0, '0, '0));
        send_item(make_item(1'b0, ones, ones, ones, ones, ones, 32'hFFFF_FFFF));
        send_item(make_item(1'b0, ones, ones, ones, '0, '0, 32'd7));
        send_item(make_item(1'b0, ones, '0, '0, '0, '0, '0));
        send_item(make_item(1'b0, '0, ones, ones, ones, ones, 32'd3));
        send_item(make_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFE, '0, ones, ones, '0, 32'd1));
        send_item(make_item(1'b1, ones, ones, ones, '0, '0, '0));
        send_item(make_item(1'b1, '0, ones, ones, ones, ones, '0));
        send_item(make_item(1'b1, 64'h5555_5555_5555_5555, '0, '0, 64'h1, '0, '0));
        set_thresholds(7'd0, 7'd0);
        for (int i = 0; i < 14; i++)
            send_item(make_item(1'b0, rand64(), owner_pool[0][0], owner_pool[0][1],
                                prov_pool[i % 3][0], prov_pool[i % 3][1], 32'(i)));
        set_thresholds(7'd127, 7'd127);

        // Random part, threshold setting changed every phase.
        for (int n = 0; n < RandomItems; n++)
        begin
            if (n % PhaseLen == 0 && n != 0)
            begin
                sel = (n / PhaseLen) % 6;
                case (sel)
                    0: set_thresholds(7'd50, 7'd50);
                    1: set_thresholds(7'd100, 7'd100);
                    2: set_thresholds(7'd0, 7'd127);
                    3: set_thresholds(ThrW'($urandom_range(0, 127)),
                                      ThrW'($urandom_range(0, 127)));
                    4: set_thresholds(7'd127, 7'd0);
                    default: set_thresholds(ThrW'($urandom_range(30, 70)),
                                            ThrW'($urandom_range(30, 70)));
                endcase
            end
            if (n == 400)
                hold_long = 1'b1;
            if (n == 700)
                wait_drained();
            if (n == RandomItems - 150)
                quiet = 1'b1;
            send_item(random_item());
        end

        wait_drained();
        repeat (60) @(posedge clk);
        $display("Run covered %0d item beats and %0d result beats over %0d threshold settings,",
                 items_sent, results_seen, settings_used);
        $display("including a long output stall and a full drain pause.");
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
